>>> src/assert_macros.svh
// Assertion macros shared by the parser RTL.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold in the same cycle as the trigger.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// The condition must hold in the cycle after the trigger.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/gorp_pkg.sv
// Package for the git object reference parser: widths, codes, the queued word type
// and the keyword character tables. No dependencies.
package gorp_pkg;

   // Length field width and saturation bound.
   localparam int LENGTH_BITS = 24;
   localparam int PROD_BITS = LENGTH_BITS + 4;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   // Queue between the classifier and the parser.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = QPTR_BITS + 1;

   // Hash geometry.
   localparam int HASH_BYTES = 20;
   localparam int HASH_IDX_BITS = $clog2(HASH_BYTES);
   localparam int HEX_DIGITS = 40;
   localparam int DIGIT_CAP = 63;

   // Characters with a meaning of their own.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ONE = 8'h31;

   // Object and reference kinds.
   localparam logic [1:0] KIND_BLOB = 2'd0;
   localparam logic [1:0] KIND_TREE = 2'd1;
   localparam logic [1:0] KIND_COMMIT = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   // Expected type code that accepts any object.
   localparam logic [1:0] EXPECT_ANY = 2'd0;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_LENGTH = 3'd1,
      ST_TYPE = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_BADREF = 3'd4,
      ST_BADHDR = 3'd5
   } gorp_status_type;

   // One classified byte as it sits in the queue.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [1:0] expected;
      logic       is_space;
      logic       is_nul;
      logic       is_newline;
      logic       is_digit;
      logic       is_hex;
      logic       is_one;
      logic [3:0] nibble;
   } gorp_byte_type;

   // Keep the first error of an object.
   function automatic gorp_status_type first_err(input gorp_status_type cur,
                                                 input gorp_status_type code);
      gorp_status_type res;
      if (cur == ST_OK) begin
         res = code;
      end else begin
         res = cur;
      end
      return res;
   endfunction

   // "blob"
   function automatic logic [7:0] blob_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0: c = 8'h62;
         3'd1: c = 8'h6C;
         3'd2: c = 8'h6F;
         3'd3: c = 8'h62;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   // "tree " (type word and commit keyword share it).
   function automatic logic [7:0] tree_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0: c = 8'h74;
         3'd1: c = 8'h72;
         3'd2: c = 8'h65;
         3'd3: c = 8'h65;
         3'd4: c = CHAR_SPACE;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   // "commit"
   function automatic logic [7:0] commit_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0: c = 8'h63;
         3'd1: c = 8'h6F;
         3'd2: c = 8'h6D;
         3'd3: c = 8'h6D;
         3'd4: c = 8'h69;
         3'd5: c = 8'h74;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   // "parent "
   function automatic logic [7:0] parent_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0: c = 8'h70;
         3'd1: c = 8'h61;
         3'd2: c = 8'h72;
         3'd3: c = 8'h65;
         3'd4: c = 8'h6E;
         3'd5: c = 8'h74;
         3'd6: c = CHAR_SPACE;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

endpackage

>>> src/gorp_front.sv
// Front end of the parser: takes request words and classifies each byte.
// Depends on gorp_pkg; feeds gorp_queue.
module gorp_front (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   input  logic [1:0]             req_expected_type,
   input  logic                   queue_full,
   output logic                   push,
   output gorp_pkg::gorp_byte_type push_entry
);
   import gorp_pkg::*;

   logic is_digit;
   logic is_lower_hex;
   logic is_upper_hex;

   // The queue has room or the source waits.
   assign req_stall = queue_full;
   assign push = req_valid && !queue_full;

   // Character classes.
   assign is_digit = (req_data_byte >= 8'h30) && (req_data_byte <= 8'h39);
   assign is_lower_hex = (req_data_byte >= 8'h61) && (req_data_byte <= 8'h66);
   assign is_upper_hex = (req_data_byte >= 8'h41) && (req_data_byte <= 8'h46);

   // Build the classified word; letters a-f and A-F map to 10-15 from their low nibble.
   always_comb begin
      push_entry.data = req_data_byte;
      push_entry.last = req_last_byte;
      push_entry.expected = req_expected_type;
      push_entry.is_space = (req_data_byte == CHAR_SPACE);
      push_entry.is_nul = (req_data_byte == CHAR_NUL);
      push_entry.is_newline = (req_data_byte == CHAR_NEWLINE);
      push_entry.is_digit = is_digit;
      push_entry.is_hex = is_digit || is_lower_hex || is_upper_hex;
      push_entry.is_one = (req_data_byte == CHAR_ONE);
      push_entry.nibble = is_digit ? req_data_byte[3:0] : (req_data_byte[3:0] + 4'd9);
   end

endmodule

>>> src/gorp_queue.sv
// Short queue of classified bytes between the front end and the parser.
// Depends on gorp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gorp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gorp_pkg::gorp_byte_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   rd_valid,
   output gorp_pkg::gorp_byte_type rd_entry
);
   import gorp_pkg::*;

   gorp_byte_type slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS-1:0] wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff;
   logic [QCOUNT_BITS-1:0] count_in;

   assign full = (count_ff == QCOUNT_BITS'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_entry = slot_ff[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : (wr_ptr_ff + 1'b1);
      rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : (rd_ptr_ff + 1'b1);
      case ({push, pop})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Pointers and count reset; the slots carry payload only.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= QCOUNT_BITS'(QUEUE_DEPTH), "queue count exceeds depth")
   `ASSERT_NXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "push alone did not grow the queue")

endmodule

>>> src/gorp_back.sv
// Parser back end: header, commit and tree state machine, hash store and result register.
// Depends on gorp_pkg and assert_macros.svh; pops words from gorp_queue.
`include "assert_macros.svh"
module gorp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_valid,
   input  gorp_pkg::gorp_byte_type rd_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_ref_valid,
   output logic [1:0]             rsp_ref_kind,
   output logic [63:0]            rsp_hash_high,
   output logic [63:0]            rsp_hash_middle,
   output logic [31:0]            rsp_hash_low,
   output logic                   rsp_object_done,
   output logic [1:0]             rsp_object_kind,
   output logic [2:0]             rsp_status
);
   import gorp_pkg::*;

   typedef enum logic [3:0] {
      PH_START = 4'd0,
      PH_TYPE = 4'd1,
      PH_LEN = 4'd2,
      PH_SKIPHDR = 4'd3,
      PH_BODY = 4'd4,
      PH_C_KEY = 4'd5,
      PH_C_HASH = 4'd6,
      PH_C_MSG = 4'd7,
      PH_T_MODE = 4'd8,
      PH_T_NAME = 4'd9,
      PH_T_HASH = 4'd10,
      PH_BAD = 4'd11
   } phase_type;

   localparam logic [2:0] MATCH_ALL = 3'b111;
   localparam logic [1:0] KEY_ALL = 2'b11;

   // Parse state.
   phase_type phase_ff, phase_in, cur;
   logic [2:0] match_ff, match_in;
   logic [2:0] tcount_ff, tcount_in;
   logic [LENGTH_BITS-1:0] dlen_ff, dlen_in;
   logic [LENGTH_BITS-1:0] bcount_ff, bcount_in;
   logic [1:0] kmatch_ff, kmatch_in;
   logic [1:0] ekind_ff, ekind_in;
   logic [5:0] hcount_ff, hcount_in;
   gorp_status_type sticky_ff, sticky_in;
   logic [1:0] expk_ff, expk_in;
   logic [7:0] hash_ff [HASH_BYTES];
   logic [7:0] hash_view [HASH_BYTES];

   // Step helpers.
   logic hs_we;
   logic hs_keep_hi;
   logic [HASH_IDX_BITS-1:0] hs_idx;
   logic [7:0] hs_data;
   logic emit;
   logic [1:0] rkind;
   logic [2:0] nb3;
   logic [1:0] nb2;
   logic [1:0] k;
   logic [PROD_BITS-1:0] prod;
   logic [1:0] out_kind;
   gorp_status_type out_status;
   logic produce;
   logic out_free;
   logic [63:0] pack_high, pack_middle;
   logic [31:0] pack_low;

   // Result register.
   logic rsp_valid_ff;
   logic rsp_ref_valid_ff;
   logic [1:0] rsp_ref_kind_ff;
   logic [63:0] rsp_hash_high_ff;
   logic [63:0] rsp_hash_middle_ff;
   logic [31:0] rsp_hash_low_ff;
   logic rsp_object_done_ff;
   logic [1:0] rsp_object_kind_ff;
   logic [2:0] rsp_status_ff;

   // Kind of a one-hot type match.
   function automatic logic [1:0] kind_of(input logic [2:0] m);
      logic [1:0] r;
      unique case (m)
         3'b001: r = KIND_BLOB;
         3'b010: r = KIND_TREE;
         3'b100: r = KIND_COMMIT;
         default: r = KIND_UNKNOWN;
      endcase
      return r;
   endfunction

   // A word moves on whenever the result register is free or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop = rd_valid && out_free;

   // Next parse state for the word at the head of the queue.
   always_comb begin
      phase_in = phase_ff;
      match_in = match_ff;
      tcount_in = tcount_ff;
      dlen_in = dlen_ff;
      bcount_in = bcount_ff;
      kmatch_in = kmatch_ff;
      ekind_in = ekind_ff;
      hcount_in = hcount_ff;
      sticky_in = sticky_ff;
      expk_in = expk_ff;
      hs_we = 1'b0;
      hs_keep_hi = 1'b0;
      hs_idx = '0;
      hs_data = '0;
      emit = 1'b0;
      rkind = KIND_BLOB;
      nb3 = '0;
      nb2 = '0;
      k = KIND_UNKNOWN;
      prod = '0;

      // The first byte of an object samples the expected type.
      cur = phase_ff;
      if (phase_ff == PH_START) begin
         expk_in = rd_entry.expected;
         cur = PH_TYPE;
      end
      phase_in = cur;

      // Body bytes are counted, saturating.
      if (cur >= PH_BODY) begin
         if (bcount_ff == LEN_MAX) begin
            sticky_in = first_err(sticky_in, ST_LENGTH);
         end else begin
            bcount_in = bcount_ff + 1'b1;
         end
      end

      unique case (cur)
         PH_TYPE: begin
            if (rd_entry.is_space) begin
               // End of the type word: keep only a candidate of full length.
               if (tcount_ff == 3'd4) begin
                  nb3 = {1'b0, match_ff[1:0]};
               end else if (tcount_ff == 3'd6) begin
                  nb3 = {match_ff[2], 2'b00};
               end
               match_in = nb3;
               phase_in = PH_LEN;
               hcount_in = '0;
               k = kind_of(nb3);
               if (k == KIND_UNKNOWN) begin
                  sticky_in = first_err(sticky_in, ST_UNKNOWN);
               end else if (expk_in != EXPECT_ANY && k != (expk_in - 2'd1)) begin
                  sticky_in = first_err(sticky_in, ST_TYPE);
               end
            end else begin
               nb3[0] = (tcount_ff < 3'd4) && match_ff[0] &&
                        (rd_entry.data == blob_char(tcount_ff));
               nb3[1] = (tcount_ff < 3'd4) && match_ff[1] &&
                        (rd_entry.data == tree_char(tcount_ff));
               nb3[2] = (tcount_ff < 3'd6) && match_ff[2] &&
                        (rd_entry.data == commit_char(tcount_ff));
               match_in = nb3;
               if (tcount_ff != 3'd7) begin
                  tcount_in = tcount_ff + 1'b1;
               end
            end
         end
         PH_LEN: begin
            if (rd_entry.is_digit) begin
               // Decimal accumulate with saturation.
               prod = ({4'b0, dlen_ff} << 3) + ({4'b0, dlen_ff} << 1) +
                      PROD_BITS'(rd_entry.nibble);
               if (prod[PROD_BITS-1:LENGTH_BITS] != '0) begin
                  dlen_in = LEN_MAX;
                  sticky_in = first_err(sticky_in, ST_LENGTH);
               end else begin
                  dlen_in = prod[LENGTH_BITS-1:0];
               end
               if (hcount_ff != 6'(DIGIT_CAP)) begin
                  hcount_in = hcount_ff + 1'b1;
               end
            end else if (rd_entry.is_nul && hcount_ff != '0) begin
               k = kind_of(match_ff);
               if (k == KIND_COMMIT) begin
                  phase_in = PH_C_KEY;
                  kmatch_in = KEY_ALL;
                  tcount_in = '0;
               end else if (k == KIND_TREE) begin
                  phase_in = PH_T_MODE;
               end else begin
                  phase_in = PH_BODY;
               end
            end else begin
               sticky_in = first_err(sticky_in, ST_BADHDR);
               phase_in = PH_SKIPHDR;
            end
         end
         PH_C_KEY: begin
            // Match the line against "tree " and "parent ".
            nb2[0] = (tcount_ff < 3'd5) && kmatch_ff[0] &&
                     (rd_entry.data == tree_char(tcount_ff));
            nb2[1] = (tcount_ff < 3'd7) && kmatch_ff[1] &&
                     (rd_entry.data == parent_char(tcount_ff));
            kmatch_in = nb2;
            tcount_in = tcount_ff + 1'b1;
            if (nb2 == '0) begin
               phase_in = PH_C_MSG;
            end else if (nb2[0] && tcount_ff == 3'd4) begin
               phase_in = PH_C_HASH;
               ekind_in = KIND_TREE;
               hcount_in = '0;
            end else if (nb2[1] && tcount_ff == 3'd6) begin
               phase_in = PH_C_HASH;
               ekind_in = KIND_COMMIT;
               hcount_in = '0;
            end
         end
         PH_C_HASH: begin
            if (rd_entry.is_newline) begin
               if (hcount_ff == 6'(HEX_DIGITS)) begin
                  emit = 1'b1;
                  rkind = ekind_ff;
                  phase_in = PH_C_KEY;
                  kmatch_in = KEY_ALL;
                  tcount_in = '0;
               end else begin
                  sticky_in = first_err(sticky_in, ST_BADREF);
                  phase_in = PH_BAD;
               end
            end else if (!rd_entry.is_hex || hcount_ff >= 6'(HEX_DIGITS)) begin
               sticky_in = first_err(sticky_in, ST_BADREF);
               phase_in = PH_BAD;
            end else begin
               // Even digits fill the high nibble and clear the low one.
               hs_we = 1'b1;
               hs_idx = hcount_ff[5:1];
               hs_keep_hi = hcount_ff[0];
               hs_data = hcount_ff[0] ? {4'b0, rd_entry.nibble} : {rd_entry.nibble, 4'b0};
               hcount_in = hcount_ff + 1'b1;
            end
         end
         PH_T_MODE: begin
            ekind_in = rd_entry.is_one ? KIND_BLOB : KIND_TREE;
            phase_in = PH_T_NAME;
         end
         PH_T_NAME: begin
            if (rd_entry.is_nul) begin
               phase_in = PH_T_HASH;
               hcount_in = '0;
            end
         end
         PH_T_HASH: begin
            if (hcount_ff < 6'(HASH_BYTES)) begin
               hs_we = 1'b1;
               hs_idx = hcount_ff[HASH_IDX_BITS-1:0];
               hs_data = rd_entry.data;
            end
            hcount_in = hcount_ff + 1'b1;
            if (hcount_in >= 6'(HASH_BYTES)) begin
               emit = 1'b1;
               rkind = ekind_ff;
               phase_in = PH_T_MODE;
            end
         end
         default: begin
         end
      endcase

      // End of object checks.
      if (rd_entry.last) begin
         if (phase_in == PH_TYPE || phase_in == PH_LEN) begin
            sticky_in = first_err(sticky_in, ST_BADHDR);
         end else if (phase_in == PH_C_HASH) begin
            if (hcount_in == 6'(HEX_DIGITS)) begin
               emit = 1'b1;
               rkind = ekind_in;
            end else begin
               sticky_in = first_err(sticky_in, ST_BADREF);
            end
         end else if (phase_in == PH_T_NAME || phase_in == PH_T_HASH) begin
            sticky_in = first_err(sticky_in, ST_BADREF);
         end
         if (sticky_in == ST_OK && dlen_in != bcount_in) begin
            sticky_in = first_err(sticky_in, ST_LENGTH);
         end
      end

      out_kind = (phase_in == PH_TYPE) ? KIND_UNKNOWN : kind_of(match_in);
      out_status = sticky_in;
      produce = emit || rd_entry.last;

      // After the last byte the parse state returns to its start value.
      if (rd_entry.last) begin
         phase_in = PH_START;
         match_in = MATCH_ALL;
         tcount_in = '0;
         dlen_in = '0;
         bcount_in = '0;
         kmatch_in = '0;
         ekind_in = KIND_BLOB;
         hcount_in = '0;
         sticky_in = ST_OK;
         expk_in = EXPECT_ANY;
      end
   end

   // Hash store with this word's write applied, and its packed form.
   always_comb begin
      for (int i = 0; i < HASH_BYTES; i++) begin
         if (hs_we && hs_idx == HASH_IDX_BITS'(i)) begin
            hash_view[i] = hs_keep_hi ? {hash_ff[i][7:4], hs_data[3:0]} : hs_data;
         end else begin
            hash_view[i] = hash_ff[i];
         end
      end
      for (int i = 0; i < 8; i++) begin
         pack_high[63-8*i -: 8] = hash_view[i];
         pack_middle[63-8*i -: 8] = hash_view[8+i];
      end
      for (int i = 0; i < 4; i++) begin
         pack_low[31-8*i -: 8] = hash_view[16+i];
      end
   end

   // State and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         match_ff <= MATCH_ALL;
         tcount_ff <= '0;
         dlen_ff <= '0;
         bcount_ff <= '0;
         kmatch_ff <= '0;
         ekind_ff <= KIND_BLOB;
         hcount_ff <= '0;
         sticky_ff <= ST_OK;
         expk_ff <= EXPECT_ANY;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            match_ff <= match_in;
            tcount_ff <= tcount_in;
            dlen_ff <= dlen_in;
            bcount_ff <= bcount_in;
            kmatch_ff <= kmatch_in;
            ekind_ff <= ekind_in;
            hcount_ff <= hcount_in;
            sticky_ff <= sticky_in;
            expk_ff <= expk_in;
         end
         if (out_free) begin
            rsp_valid_ff <= pop && produce;
         end
      end
      if (pop) begin
         hash_ff <= hash_view;
      end
      if (pop && produce) begin
         rsp_ref_valid_ff <= emit;
         rsp_ref_kind_ff <= emit ? rkind : KIND_BLOB;
         rsp_hash_high_ff <= emit ? pack_high : '0;
         rsp_hash_middle_ff <= emit ? pack_middle : '0;
         rsp_hash_low_ff <= emit ? pack_low : '0;
         rsp_object_done_ff <= rd_entry.last;
         rsp_object_kind_ff <= rd_entry.last ? out_kind : KIND_BLOB;
         rsp_status_ff <= rd_entry.last ? out_status : ST_OK;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ref_valid = rsp_ref_valid_ff;
   assign rsp_ref_kind = rsp_ref_kind_ff;
   assign rsp_hash_high = rsp_hash_high_ff;
   assign rsp_hash_middle = rsp_hash_middle_ff;
   assign rsp_hash_low = rsp_hash_low_ff;
   assign rsp_object_done = rsp_object_done_ff;
   assign rsp_object_kind = rsp_object_kind_ff;
   assign rsp_status = rsp_status_ff;

   `ASSERT_NXT(a_last_restarts, clock, reset, pop && rd_entry.last, phase_ff == PH_START, "parser did not restart after the last byte")
   `ASSERT_IMP(a_status_on_done, clock, reset, rsp_valid_ff && !rsp_object_done_ff, rsp_status_ff == ST_OK, "status given on a word that does not end an object")
   `ASSERT_IMP(a_hash_clear, clock, reset, rsp_valid_ff && !rsp_ref_valid_ff, rsp_hash_low_ff == '0 && rsp_hash_high_ff == '0, "hash given without a reference")

endmodule

>>> src/git_object_reference_parser_top.sv
// Git object reference parser, top level: links front end, queue and parser.
// Depends on gorp_pkg, gorp_front, gorp_queue and gorp_back.
//
// Usage:
//   The req_ channel carries one byte of a decompressed object per word, header
//   first, with req_last_byte on the final byte; req_expected_type is taken from
//   the first byte of each object. The rsp_ channel returns one word when a
//   reference hash completes, when an object ends, or both in the same word.
//   Throughput is one byte per cycle unless rsp_stall holds a result word.
//   A byte taken into an empty queue is stored in a queue slot, then its result
//   word is registered. A four-word queue sits between the classifier and the
//   parser, so req_stall rises only once four bytes wait behind a stalled
//   result word; rsp_stall holds a valid result word and pauses the parser.
//   Bytes that produce no result are consumed without a word on rsp_.
//   Synchronous reset empties the queue, drops any pending result and returns
//   the parser to the start of a header. The hash store has no clearing pass and
//   the block accepts bytes in the first cycle after reset.
module git_object_reference_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [1:0]  req_expected_type,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ref_valid,
   output logic [1:0]  rsp_ref_kind,
   output logic [63:0] rsp_hash_high,
   output logic [63:0] rsp_hash_middle,
   output logic [31:0] rsp_hash_low,
   output logic        rsp_object_done,
   output logic [1:0]  rsp_object_kind,
   output logic [2:0]  rsp_status
);
   import gorp_pkg::*;

   logic push;
   logic queue_full;
   logic pop;
   logic rd_valid;
   gorp_byte_type push_entry;
   gorp_byte_type rd_entry;

   // Classify incoming bytes.
   gorp_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .req_expected_type (req_expected_type),
      .queue_full        (queue_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   // Decouple the two sides.
   gorp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .rd_valid   (rd_valid),
      .rd_entry   (rd_entry)
   );

   // Parse and deliver results.
   gorp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .rd_valid        (rd_valid),
      .rd_entry        (rd_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ref_valid   (rsp_ref_valid),
      .rsp_ref_kind    (rsp_ref_kind),
      .rsp_hash_high   (rsp_hash_high),
      .rsp_hash_middle (rsp_hash_middle),
      .rsp_hash_low    (rsp_hash_low),
      .rsp_object_done (rsp_object_done),
      .rsp_object_kind (rsp_object_kind),
      .rsp_status      (rsp_status)
   );

endmodule

>>> tb/git_object_reference_parser_top_test.sv
// Self-checking testbench for git_object_reference_parser_top: feeds whole objects a
// byte per word and checks every result word against a built-in parse tracker.
// Depends on gorp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module git_object_reference_parser_top_test;
   import gorp_pkg::*;

   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_BYTES = 200;
   localparam int DRAIN_CYCLES = 20;

   // Expected type codes besides "any".
   localparam logic [1:0] EXPECT_BLOB = 2'd1;
   localparam logic [1:0] EXPECT_TREE = 2'd2;
   localparam logic [1:0] EXPECT_COMMIT = 2'd3;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // Words and keywords, right-aligned.
   localparam logic [55:0] BLOB_WORD = "blob";
   localparam logic [55:0] COMMIT_WORD = "commit";
   localparam logic [55:0] TREE_KEY = "tree ";
   localparam logic [55:0] PARENT_KEY = "parent ";

   typedef enum logic [3:0] {
      PH_START, PH_TYPE, PH_LEN, PH_SKIP_HEADER, PH_BODY, PH_KEY, PH_HASH_TEXT,
      PH_MESSAGE, PH_MODE, PH_NAME, PH_HASH_RAW, PH_BROKEN
   } parse_phase_type;

   typedef struct packed {
      logic            ref_valid;
      logic [1:0]      ref_kind;
      logic [63:0]     hash_high;
      logic [63:0]     hash_middle;
      logic [31:0]     hash_low;
      logic            object_done;
      logic [1:0]      object_kind;
      gorp_status_type status;
   } parse_word_type;

   // Tracks the parse of the current object and queues the result words it implies.
   class parse_tracker_type;
      parse_word_type awaited_words[$];
      int faults;
      int words_seen;
      int refs_seen;
      int objects_seen;

      parse_phase_type phase;
      logic [2:0] kind_bits;
      int word_pos;
      logic [LENGTH_BITS-1:0] decl_len;
      logic [LENGTH_BITS-1:0] body_cnt;
      logic [1:0] key_bits;
      logic [1:0] line_kind;
      logic [7:0] digest [HASH_BYTES];
      int digits;
      gorp_status_type verdict;
      logic [1:0] wanted_type;

      function new();
         clear();
      endfunction

      function void clear();
         phase = PH_START;
         kind_bits = 3'b111;
         word_pos = 0;
         decl_len = '0;
         body_cnt = '0;
         key_bits = 2'b00;
         line_kind = KIND_BLOB;
         foreach (digest[i]) digest[i] = 8'h00;
         digits = 0;
         verdict = ST_OK;
         wanted_type = EXPECT_ANY;
      endfunction

      function void raise(gorp_status_type code);
         if (verdict == ST_OK) verdict = code;
      endfunction

      function logic [7:0] letter(logic [55:0] word, int len, int pos);
         return word[8*(len-1-pos) +: 8];
      endfunction

      function int nibble_of(logic [7:0] b);
         if (b >= "0" && b <= "9") return int'(b - "0");
         if (b >= "a" && b <= "f") return int'(b - "a") + 10;
         if (b >= "A" && b <= "F") return int'(b - "A") + 10;
         return -1;
      endfunction

      function logic [1:0] kind_now();
         if (phase <= PH_TYPE) return KIND_UNKNOWN;
         case (kind_bits)
            3'b001: return KIND_BLOB;
            3'b010: return KIND_TREE;
            3'b100: return KIND_COMMIT;
            default: return KIND_UNKNOWN;
         endcase
      endfunction

      function void start_line();
         phase = PH_KEY;
         key_bits = 2'b11;
         word_pos = 0;
      endfunction

      // One accepted byte: advance the parse and queue the word it causes, if any.
      function void take_byte(logic [7:0] b, logic last, logic [1:0] et);
         parse_word_type w;
         logic emit;
         logic [1:0] rkind;
         logic [2:0] nb;
         logic [1:0] nk;
         logic [63:0] wide;
         int h;
         int p;
         emit = 1'b0;
         rkind = KIND_BLOB;
         if (phase == PH_START) begin
            wanted_type = et;
            phase = PH_TYPE;
         end
         if (phase >= PH_BODY) begin
            if (body_cnt >= LEN_MAX) raise(ST_LENGTH);
            else body_cnt++;
         end

         case (phase)
            PH_TYPE: begin
               if (b == CHAR_SPACE) begin
                  // The word must have ended exactly on a full candidate.
                  nb = 3'b000;
                  if (word_pos == 4) nb[1:0] = kind_bits[1:0];
                  if (word_pos == 6) nb[2] = kind_bits[2];
                  kind_bits = nb;
                  phase = PH_LEN;
                  digits = 0;
                  if (kind_now() == KIND_UNKNOWN) raise(ST_UNKNOWN);
                  else if (wanted_type != EXPECT_ANY && kind_now() != wanted_type - 1)
                     raise(ST_TYPE);
               end else begin
                  p = word_pos;
                  nb = 3'b000;
                  if (p < 4 && kind_bits[0] && b == letter(BLOB_WORD, 4, p)) nb[0] = 1'b1;
                  if (p < 4 && kind_bits[1] && b == letter(TREE_KEY, 5, p)) nb[1] = 1'b1;
                  if (p < 6 && kind_bits[2] && b == letter(COMMIT_WORD, 6, p)) nb[2] = 1'b1;
                  kind_bits = nb;
                  if (word_pos < 7) word_pos++;
               end
            end
            PH_LEN: begin
               if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                  wide = 64'(decl_len) * 64'd10 + 64'(b - CHAR_ZERO);
                  if (wide > 64'(LEN_MAX)) begin
                     wide = 64'(LEN_MAX);
                     raise(ST_LENGTH);
                  end
                  decl_len = wide[LENGTH_BITS-1:0];
                  if (digits < DIGIT_CAP) digits++;
               end else if (b == CHAR_NUL && digits != 0) begin
                  case (kind_now())
                     KIND_COMMIT: start_line();
                     KIND_TREE: phase = PH_MODE;
                     default: phase = PH_BODY;
                  endcase
               end else begin
                  raise(ST_BADHDR);
                  phase = PH_SKIP_HEADER;
               end
            end
            PH_KEY: begin
               p = word_pos;
               nk = 2'b00;
               if (p < 5 && key_bits[0] && b == letter(TREE_KEY, 5, p)) nk[0] = 1'b1;
               if (p < 7 && key_bits[1] && b == letter(PARENT_KEY, 7, p)) nk[1] = 1'b1;
               key_bits = nk;
               word_pos = (p + 1) % 8;
               if (nk == 2'b00) begin
                  phase = PH_MESSAGE;
               end else if (nk[0] && p == 4) begin
                  phase = PH_HASH_TEXT;
                  line_kind = KIND_TREE;
                  digits = 0;
               end else if (nk[1] && p == 6) begin
                  phase = PH_HASH_TEXT;
                  line_kind = KIND_COMMIT;
                  digits = 0;
               end
            end
            PH_HASH_TEXT: begin
               if (b == CHAR_NEWLINE) begin
                  if (digits == HEX_DIGITS) begin
                     emit = 1'b1;
                     rkind = line_kind;
                     start_line();
                  end else begin
                     raise(ST_BADREF);
                     phase = PH_BROKEN;
                  end
               end else begin
                  h = nibble_of(b);
                  if (h < 0 || digits >= HEX_DIGITS) begin
                     raise(ST_BADREF);
                     phase = PH_BROKEN;
                  end else begin
                     if (digits % 2 == 0) digest[digits/2] = {h[3:0], 4'h0};
                     else digest[digits/2][3:0] = h[3:0];
                     digits++;
                  end
               end
            end
            PH_MODE: begin
               line_kind = (b == CHAR_ONE) ? KIND_BLOB : KIND_TREE;
               phase = PH_NAME;
            end
            PH_NAME: begin
               if (b == CHAR_NUL) begin
                  phase = PH_HASH_RAW;
                  digits = 0;
               end
            end
            PH_HASH_RAW: begin
               if (digits < HASH_BYTES) digest[digits] = b;
               digits++;
               if (digits >= HASH_BYTES) begin
                  emit = 1'b1;
                  rkind = line_kind;
                  phase = PH_MODE;
               end
            end
            default: ;
         endcase

         // End of object: close open constructs and check the length.
         if (last) begin
            if (phase <= PH_LEN) begin
               raise(ST_BADHDR);
            end else if (phase == PH_HASH_TEXT) begin
               if (digits == HEX_DIGITS) begin
                  emit = 1'b1;
                  rkind = line_kind;
               end else begin
                  raise(ST_BADREF);
               end
            end else if (phase == PH_NAME || phase == PH_HASH_RAW) begin
               raise(ST_BADREF);
            end
            if (verdict == ST_OK && decl_len != body_cnt) raise(ST_LENGTH);
         end

         if (emit || last) begin
            w = '0;
            w.status = ST_OK;
            if (emit) begin
               w.ref_valid = 1'b1;
               w.ref_kind = rkind;
               for (int i = 0; i < HASH_BYTES; i++) begin
                  if (i < 8) w.hash_high = {w.hash_high[55:0], digest[i]};
                  else if (i < 16) w.hash_middle = {w.hash_middle[55:0], digest[i]};
                  else w.hash_low = {w.hash_low[23:0], digest[i]};
               end
            end
            if (last) begin
               w.object_done = 1'b1;
               w.object_kind = kind_now();
               w.status = verdict;
            end
            awaited_words.push_back(w);
         end
         if (last) clear();
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            faults++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         end
      endfunction

      // One accepted result word against the oldest expectation.
      function void match_word(parse_word_type got);
         parse_word_type want;
         words_seen++;
         if (awaited_words.size() == 0) begin
            faults++;
            $display("%0t: result word with nothing expected, got ref_valid %0h done %0h",
                     $time, got.ref_valid, got.object_done);
            return;
         end
         want = awaited_words.pop_front();
         if (want.ref_valid) refs_seen++;
         if (want.object_done) objects_seen++;
         check_field("ref_valid", want.ref_valid, got.ref_valid);
         check_field("ref_kind", want.ref_kind, got.ref_kind);
         check_field("hash_high", want.hash_high, got.hash_high);
         check_field("hash_middle", want.hash_middle, got.hash_middle);
         check_field("hash_low", want.hash_low, got.hash_low);
         check_field("object_done", want.object_done, got.object_done);
         check_field("object_kind", want.object_kind, got.object_kind);
         check_field("status", want.status, got.status);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic [1:0]  req_expected_type = EXPECT_ANY;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ref_valid;
   logic [1:0]  rsp_ref_kind;
   logic [63:0] rsp_hash_high;
   logic [63:0] rsp_hash_middle;
   logic [31:0] rsp_hash_low;
   logic        rsp_object_done;
   logic [1:0]  rsp_object_kind;
   logic [2:0]  rsp_status;

   parse_tracker_type tracker = new();
   logic [7:0] object_bytes[$];
   int bytes_sent = 0;
   int objects_sent = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int run_left = 0;
   logic run_stalled = 1'b0;

   git_object_reference_parser_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .req_expected_type(req_expected_type),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_ref_valid(rsp_ref_valid),
      .rsp_ref_kind(rsp_ref_kind),
      .rsp_hash_high(rsp_hash_high),
      .rsp_hash_middle(rsp_hash_middle),
      .rsp_hash_low(rsp_hash_low),
      .rsp_object_done(rsp_object_done),
      .rsp_object_kind(rsp_object_kind),
      .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver stall: switches between no stall, sparse, long runs and heavy stall.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(40, 300);
      end else begin
         mode_left--;
      end
      if (run_left > 0) begin
         run_left--;
      end else begin
         run_stalled = !run_stalled;
         run_left = $urandom_range(1, 12);
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= run_stalled;
         default: rsp_stall <= ($urandom_range(0, 1) == 1);
      endcase
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.match_word(parse_word_type'({rsp_ref_valid, rsp_ref_kind, rsp_hash_high,
                                              rsp_hash_middle, rsp_hash_low,
                                              rsp_object_done, rsp_object_kind,
                                              rsp_status}));
   end

   // Watchdog on cycles where neither channel moves a word.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic void put_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) object_bytes.push_back(s[i]);
   endfunction

   function automatic void put_random(int n);
      int i;
      for (i = 0; i < n; i++) object_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Hex digits in mixed case.
   function automatic void put_hex(int n);
      string alphabet;
      int i;
      alphabet = "0123456789abcdefABCDEF";
      for (i = 0; i < n; i++) object_bytes.push_back(alphabet[$urandom_range(0, 21)]);
   endfunction

   function automatic void put_hash_line(string key, int n);
      put_text(key);
      put_hex(n);
      object_bytes.push_back(CHAR_NEWLINE);
   endfunction

   // Tree entry: mode, space, name, NUL, 20 raw hash bytes (fill below zero means random).
   function automatic void put_entry(string mode, int fill);
      int i;
      put_text(mode);
      put_text(" ");
      for (i = 0; i < $urandom_range(1, 6); i++)
         object_bytes.push_back(8'($urandom_range(1, 255)));
      object_bytes.push_back(CHAR_NUL);
      for (i = 0; i < HASH_BYTES; i++)
         object_bytes.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
   endfunction

   function automatic string body_length(int delta);
      int n;
      n = object_bytes.size() + delta;
      if (n < 0) n = 0;
      return $sformatf("%0d", n);
   endfunction

   // Put the header in front of the body built so far.
   function automatic void wrap_header(string word, string digits);
      string h;
      int i;
      h = {word, " ", digits};
      object_bytes.push_front(CHAR_NUL);
      for (i = h.len() - 1; i >= 0; i--) object_bytes.push_front(h[i]);
   endfunction

   task automatic send_byte(logic [7:0] b, logic last, logic [1:0] et);
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      req_expected_type <= et;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_byte(b, last, et);
      bytes_sent++;
      // Bursts of random length; now and then a long one with no gap at all.
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(0, 12);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Only the first word's type tag counts, so the rest carry random tags.
   task automatic send_object(logic [1:0] et);
      int i;
      logic [1:0] tag;
      for (i = 0; i < object_bytes.size(); i++) begin
         tag = (i == 0) ? et : 2'($urandom_range(0, 3));
         send_byte(object_bytes[i], i == object_bytes.size() - 1, tag);
      end
      object_bytes.delete();
      objects_sent++;
   endtask

   task automatic run_directed();
      // Empty blob, and a short blob of the expected type.
      wrap_header("blob", body_length(0));
      send_object(EXPECT_ANY);
      put_text("abc");
      wrap_header("blob", body_length(0));
      send_object(EXPECT_BLOB);
      // Extreme byte values in a blob that was expected to be a tree.
      object_bytes.push_back(8'h00);
      object_bytes.push_back(8'hFF);
      wrap_header("blob", body_length(0));
      send_object(EXPECT_TREE);
      // An unknown word outranks a type mismatch; an empty word is unknown too.
      wrap_header("blobx", body_length(0));
      send_object(EXPECT_COMMIT);
      wrap_header("", body_length(0));
      send_object(EXPECT_ANY);
      // Bad length character, NUL with no digits, header cut short.
      put_text("blob 1x");
      object_bytes.push_back(CHAR_NUL);
      put_text("a");
      send_object(EXPECT_ANY);
      put_text("tree ");
      object_bytes.push_back(CHAR_NUL);
      send_object(EXPECT_ANY);
      put_text("blo");
      send_object(EXPECT_BLOB);
      // Leading zeros, a body shorter than declared, and a length that saturates.
      put_text("ab");
      wrap_header("blob", "0002");
      send_object(EXPECT_ANY);
      put_text("abc");
      wrap_header("blob", "5");
      send_object(EXPECT_ANY);
      put_text("ab");
      wrap_header("blob", "99999999");
      send_object(EXPECT_ANY);
      // Well-formed commit: tree, two parents, then a message.
      put_hash_line("tree ", HEX_DIGITS);
      put_hash_line("parent ", HEX_DIGITS);
      put_hash_line("parent ", HEX_DIGITS);
      put_text("author x\n");
      wrap_header("commit", body_length(0));
      send_object(EXPECT_COMMIT);
      // Non-hex digit, a short hash and a long one.
      put_text("tree ");
      put_hex(20);
      put_text("g");
      put_hex(19);
      put_text("\n");
      wrap_header("commit", body_length(0));
      send_object(EXPECT_ANY);
      put_hash_line("parent ", HEX_DIGITS - 1);
      wrap_header("commit", body_length(0));
      send_object(EXPECT_ANY);
      put_hash_line("tree ", HEX_DIGITS + 1);
      wrap_header("commit", body_length(0));
      send_object(EXPECT_ANY);
      // Object ending right after a full hash, and after a partial one.
      put_text("tree ");
      put_hex(HEX_DIGITS);
      wrap_header("commit", body_length(0));
      send_object(EXPECT_COMMIT);
      put_text("parent ");
      put_hex(12);
      wrap_header("commit", body_length(0));
      send_object(EXPECT_ANY);
      // A first line that is no reference ends the list.
      put_text("treeX\n");
      put_hash_line("tree ", HEX_DIGITS);
      wrap_header("commit", body_length(0));
      send_object(EXPECT_ANY);
      // Type error and wrong length: the first error stays, the reference still comes.
      put_hash_line("tree ", HEX_DIGITS);
      wrap_header("commit", body_length(1));
      send_object(EXPECT_TREE);
      // Tree entries for blobs and a subtree, with all-zero, all-one and random hashes.
      put_entry("100644", 8'h00);
      put_entry("40000", 8'hFF);
      put_entry("100755", -1);
      wrap_header("tree", body_length(0));
      send_object(EXPECT_TREE);
      // Tree ending inside a name, and inside a hash.
      put_text("100644 ab");
      wrap_header("tree", body_length(0));
      send_object(EXPECT_ANY);
      put_text("40000 d");
      object_bytes.push_back(CHAR_NUL);
      put_random(10);
      wrap_header("tree", body_length(0));
      send_object(EXPECT_TREE);
   endtask

   // Mostly well-formed objects with random content; a quarter get damaged.
   task automatic send_random_object();
      int kind;
      int n;
      int i;
      int shape;
      int delta;
      bit flawed;
      string word;
      logic [1:0] et;
      kind = $urandom_range(0, 2);
      flawed = ($urandom_range(0, 3) == 0);
      shape = flawed ? $urandom_range(0, 5) : -1;
      delta = 0;
      case (kind)
         KIND_BLOB: begin
            word = "blob";
            put_random($urandom_range(0, 12));
         end
         KIND_TREE: begin
            word = "tree";
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
               case ($urandom_range(0, 3))
                  0: put_entry("100644", -1);
                  1: put_entry("100755", -1);
                  2: put_entry("40000", -1);
                  default: put_entry("160000", -1);
               endcase
            end
         end
         default: begin
            word = "commit";
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++)
               put_hash_line(($urandom_range(0, 1) == 1) ? "parent " : "tree ", HEX_DIGITS);
            if ($urandom_range(0, 1) == 1) begin
               put_text("author x\n");
               put_random($urandom_range(0, 8));
            end
         end
      endcase
      et = ($urandom_range(0, 1) == 1) ? EXPECT_ANY : 2'(kind + 1);

      case (shape)
         1: delta = $urandom_range(1, 3) * (($urandom_range(0, 1) == 1) ? 1 : -1);
         2: et = 2'($urandom_range(0, 3));
         3: begin
            case ($urandom_range(0, 3))
               0: word = "comit";
               1: word = "blobs";
               2: word = "Tree";
               default: word = "tre";
            endcase
         end
         default: ;
      endcase

      if (shape == 5) begin
         // Pure noise, no header.
         object_bytes.delete();
         put_random($urandom_range(1, 8));
      end else begin
         wrap_header(word, body_length(delta));
      end
      if (shape == 0)
         object_bytes[$urandom_range(0, object_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      if (shape == 4)
         object_bytes = object_bytes[0:$urandom_range(1, object_bytes.size()) - 1];
      send_object(et);
   endtask

   initial begin
      int random_start;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      random_start = bytes_sent;
      while (bytes_sent < random_start + RANDOM_BYTES) send_random_object();
      req_valid <= 1'b0;
      while (tracker.awaited_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d objects in %0d bytes with random gaps and result stalls.",
               objects_sent, bytes_sent);
      $display("Checked %0d result words: %0d references, %0d object ends, %0d errors.",
               tracker.words_seen, tracker.refs_seen, tracker.objects_seen, tracker.faults);
      if (tracker.faults == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
